// File: src/ansi_csi_terminal_parser_unit_defines.svh
// Assertion macros used by the checker file of the parser unit.
`ifndef ANSI_CSI_TERMINAL_PARSER_UNIT_DEFINES_SVH
`define ANSI_CSI_TERMINAL_PARSER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ACSI_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ACSI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/acsi_pkg.sv
`timescale 1ns / 1ps

package acsi_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int ATTR_W    = 8;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    // Screen geometry and reciprocals for the wrap reduction (pos < 256)
    localparam int SCREEN_ROWS = 24;
    localparam int SCREEN_COLS = 80;
    localparam logic [15:0] RECIP_ROWS = 16'((65536 + SCREEN_ROWS - 1) / SCREEN_ROWS);
    localparam logic [15:0] RECIP_COLS = 16'((65536 + SCREEN_COLS - 1) / SCREEN_COLS);

    // Characters
    localparam logic [7:0] CHR_ESC      = 8'h1B;
    localparam logic [7:0] CHR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHR_SEMI     = 8'h3B;
    localparam logic [7:0] CHR_0        = 8'h30;
    localparam logic [7:0] CHR_9        = 8'h39;
    localparam logic [7:0] CHR_UP       = 8'h41;
    localparam logic [7:0] CHR_DOWN     = 8'h42;
    localparam logic [7:0] CHR_RIGHT    = 8'h43;
    localparam logic [7:0] CHR_LEFT     = 8'h44;
    localparam logic [7:0] CHR_POS_H    = 8'h48;
    localparam logic [7:0] CHR_CLEAR    = 8'h4A;
    localparam logic [7:0] CHR_EOL      = 8'h4B;
    localparam logic [7:0] CHR_POS_F    = 8'h66;
    localparam logic [7:0] CHR_SGR      = 8'h6D;
    localparam logic [7:0] CHR_SAVE     = 8'h73;
    localparam logic [7:0] CHR_RESTORE  = 8'h75;

    // Attribute codes and bits
    localparam logic [7:0] SGR_RESET     = 8'd0;
    localparam logic [7:0] SGR_BOLD      = 8'd1;
    localparam logic [7:0] SGR_UNDERLINE = 8'd4;
    localparam logic [7:0] SGR_BLINK     = 8'd5;
    localparam logic [7:0] SGR_REVERSE   = 8'd7;
    localparam logic [7:0] ATTR_BLINK_BIT     = 8'h80;
    localparam logic [7:0] ATTR_UNDERLINE_BIT = 8'h01;

    // Reset values of the attribute registers
    localparam logic [7:0] ATTR_DEFAULT_RST = 8'd7;
    localparam logic [7:0] ATTR_REVERSE_RST = 8'd112;
    localparam logic [7:0] ATTR_BOLD_RST    = 8'd15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_DEFAULT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_REVERSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_BOLD    = 2'd2;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_EOL   = 2'd2,
        CMD_MOVE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DECODE = 3'd1,
        S_SGR    = 3'd2,
        S_QUOT   = 3'd3,
        S_REM    = 3'd4,
        S_DONE   = 3'd5
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic decode;
        logic sgr_step;
        logic mod_quot;
        logic mod_rem;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sgr_go;
        logic mod_go;
        logic sgr_last;
    } dp_status_t;

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

endpackage

// File: src/acsi_ctrl.sv
`timescale 1ns / 1ps

module acsi_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  acsi_pkg::dp_status_t   status,
    output acsi_pkg::ctrl_cmd_t    cmd
);

    acsi_pkg::ctrl_state_t state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            acsi_pkg::S_IDLE: begin
                if (s_tvalid) state_next = acsi_pkg::S_DECODE;
            end
            acsi_pkg::S_DECODE: begin
                if (status.sgr_go)      state_next = acsi_pkg::S_SGR;
                else if (status.mod_go) state_next = acsi_pkg::S_QUOT;
                else                    state_next = acsi_pkg::S_DONE;
            end
            acsi_pkg::S_SGR: begin
                if (status.sgr_last) state_next = acsi_pkg::S_DONE;
            end
            acsi_pkg::S_QUOT: state_next = acsi_pkg::S_REM;
            acsi_pkg::S_REM:  state_next = acsi_pkg::S_DONE;
            acsi_pkg::S_DONE: begin
                if (out_free) state_next = acsi_pkg::S_IDLE;
            end
            default: state_next = acsi_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            acsi_pkg::S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            acsi_pkg::S_DECODE: cmd.decode   = 1'b1;
            acsi_pkg::S_SGR:    cmd.sgr_step = 1'b1;
            acsi_pkg::S_QUOT:   cmd.mod_quot = 1'b1;
            acsi_pkg::S_REM:    cmd.mod_rem  = 1'b1;
            acsi_pkg::S_DONE:   cmd.load_out = out_free;
            default: cmd = '0;
        endcase
    end

    // Hold the result word until taken
    always_comb begin
        if (cmd.load_out)  m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
        else               m_tvalid_next = m_tvalid_reg;
    end

    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= acsi_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// File: src/acsi_dp.sv
`timescale 1ns / 1ps

module acsi_dp #(
    parameter int MAX_PARAMS = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [acsi_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic [acsi_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [acsi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acsi_pkg::CFG_W-1:0]          cfg_wdata,
    input  acsi_pkg::ctrl_cmd_t                 cmd,
    output acsi_pkg::dp_status_t                status
);

    localparam int CNT_W = $clog2(MAX_PARAMS + 1);
    localparam int IDX_W = $clog2(MAX_PARAMS);

    // Captured word
    logic [7:0]                 byte_reg;
    logic [acsi_pkg::ROW_W-1:0] row_reg;
    logic [acsi_pkg::COL_W-1:0] col_reg;

    // Parser state
    acsi_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       pval_reg [MAX_PARAMS];
    logic [7:0]       pval_next [MAX_PARAMS];
    logic [CNT_W-1:0] pcnt_reg, pcnt_next;
    logic             in_num_reg, in_num_next;
    logic             lead_semi_reg, lead_semi_next;
    logic             any_char_reg, any_char_next;
    logic [acsi_pkg::ROW_W-1:0]  saved_row_reg, saved_row_next;
    logic [acsi_pkg::COL_W-1:0]  saved_col_reg, saved_col_next;
    logic [acsi_pkg::ATTR_W-1:0] attr_reg, attr_next;
    logic [7:0] attr_default_reg, attr_reverse_reg, attr_bold_reg;

    // Working result
    logic                        show_reg, show_next;
    acsi_pkg::cmd_t              cmd_reg, cmd_next;
    logic [acsi_pkg::ROW_W-1:0]  nr_reg, nr_next;
    logic [acsi_pkg::COL_W-1:0]  nc_reg, nc_next;
    logic [7:0]                  pos_reg, pos_next;
    logic                        mod_col_reg, mod_col_next;
    logic [7:0]                  quot_reg;
    logic [CNT_W-1:0]            sgr_idx_reg, sgr_idx_next;
    logic [acsi_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // Shared read port of the parameter file
    logic [CNT_W-1:0] pcnt_m1;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       rd_val;
    logic [CNT_W-1:0] sgr_idx_inc;

    // Decode helpers
    logic       csi_letter;
    logic [7:0] step;
    logic [7:0] row8, col8;
    logic [7:0] acc;
    logic [7:0] pos_r, pos_c, pos_r_m1, pos_c_m1;
    logic       pos_ok;

    // Wrap reduction
    logic [23:0] quot_prod;
    logic [15:0] back_prod;
    logic [7:0]  rem;

    assign pcnt_m1     = pcnt_reg - CNT_W'(1);
    assign rd_idx      = cmd.sgr_step ? sgr_idx_reg[IDX_W-1:0] : pcnt_m1[IDX_W-1:0];
    assign rd_val      = (CNT_W'(rd_idx) < CNT_W'(MAX_PARAMS)) ? pval_reg[rd_idx] : 8'd0;
    assign sgr_idx_inc = sgr_idx_reg + CNT_W'(1);

    assign row8 = {3'b000, row_reg};
    assign col8 = {1'b0, col_reg};
    assign step = (pcnt_reg != '0) ? pval_reg[0] : 8'd1;
    assign acc  = {rd_val[4:0], 3'b000} + {rd_val[6:0], 1'b0} + {4'b0000, byte_reg[3:0]};
    assign csi_letter = (phase_reg == acsi_pkg::PH_CSI) && acsi_pkg::is_letter(byte_reg);

    // Status for the controller
    assign status.sgr_go   = csi_letter && (byte_reg == acsi_pkg::CHR_SGR) && (pcnt_reg != '0);
    assign status.mod_go   = csi_letter && ((byte_reg == acsi_pkg::CHR_UP) ||
                             (byte_reg == acsi_pkg::CHR_DOWN) ||
                             (byte_reg == acsi_pkg::CHR_RIGHT) ||
                             (byte_reg == acsi_pkg::CHR_LEFT));
    assign status.sgr_last = (sgr_idx_inc >= pcnt_reg);

    // Row and column of an absolute position command
    always_comb begin
        pos_r = pval_reg[0];
        pos_c = 8'd1;
        if (pcnt_reg == CNT_W'(2)) begin
            pos_c = pval_reg[1];
        end else if (lead_semi_reg) begin
            pos_c = pval_reg[0];
            pos_r = 8'd1;
        end
        if (pos_r == 8'd0) pos_r = 8'd1;
        if (pos_c == 8'd0) pos_c = 8'd1;
        pos_r_m1 = pos_r - 8'd1;
        pos_c_m1 = pos_c - 8'd1;
        pos_ok   = (pcnt_reg <= CNT_W'(2)) &&
                   (pos_r <= 8'(acsi_pkg::SCREEN_ROWS)) &&
                   (pos_c <  8'(acsi_pkg::SCREEN_COLS));
    end

    // Reduce the wrapped position: quotient by reciprocal, then remainder
    assign quot_prod = pos_reg * (mod_col_reg ? acsi_pkg::RECIP_COLS : acsi_pkg::RECIP_ROWS);
    assign back_prod = quot_reg * (mod_col_reg ? 8'(acsi_pkg::SCREEN_COLS)
                                               : 8'(acsi_pkg::SCREEN_ROWS));
    assign rem       = pos_reg - back_prod[7:0];

    // Parser state update, attribute loop and result fields
    always_comb begin
        phase_next     = phase_reg;
        pval_next      = pval_reg;
        pcnt_next      = pcnt_reg;
        in_num_next    = in_num_reg;
        lead_semi_next = lead_semi_reg;
        any_char_next  = any_char_reg;
        saved_row_next = saved_row_reg;
        saved_col_next = saved_col_reg;
        attr_next      = attr_reg;
        show_next      = show_reg;
        cmd_next       = cmd_reg;
        nr_next        = nr_reg;
        nc_next        = nc_reg;
        pos_next       = pos_reg;
        mod_col_next   = mod_col_reg;
        sgr_idx_next   = sgr_idx_reg;

        if (cmd.decode) begin
            show_next    = 1'b0;
            cmd_next     = acsi_pkg::CMD_NONE;
            nr_next      = '0;
            nc_next      = '0;
            sgr_idx_next = '0;
            if (byte_reg == acsi_pkg::CHR_ESC) begin
                // Drop any open sequence and start a new one
                for (int i = 0; i < MAX_PARAMS; i++) pval_next[i] = 8'd0;
                pcnt_next      = '0;
                in_num_next    = 1'b0;
                lead_semi_next = 1'b0;
                any_char_next  = 1'b0;
                phase_next     = acsi_pkg::PH_ESC;
            end else if (phase_reg == acsi_pkg::PH_IDLE) begin
                show_next = 1'b1;
            end else if (phase_reg == acsi_pkg::PH_ESC) begin
                phase_next = (byte_reg == acsi_pkg::CHR_LBRACKET) ? acsi_pkg::PH_CSI
                                                                  : acsi_pkg::PH_IDLE;
            end else if (!csi_letter) begin
                // Parameter bytes
                if (!any_char_reg && (byte_reg == acsi_pkg::CHR_SEMI)) lead_semi_next = 1'b1;
                any_char_next = 1'b1;
                if ((byte_reg >= acsi_pkg::CHR_0) && (byte_reg <= acsi_pkg::CHR_9)) begin
                    if (in_num_reg) begin
                        for (int i = 0; i < MAX_PARAMS; i++) begin
                            if (pcnt_m1[IDX_W-1:0] == IDX_W'(i)) pval_next[i] = acc;
                        end
                    end else if (pcnt_reg < CNT_W'(MAX_PARAMS)) begin
                        for (int i = 0; i < MAX_PARAMS; i++) begin
                            if (pcnt_reg[IDX_W-1:0] == IDX_W'(i)) begin
                                pval_next[i] = {4'b0000, byte_reg[3:0]};
                            end
                        end
                        pcnt_next   = pcnt_reg + CNT_W'(1);
                        in_num_next = 1'b1;
                    end
                end else begin
                    in_num_next = 1'b0;
                end
            end else begin
                // Final letter: run the command
                phase_next = acsi_pkg::PH_IDLE;
                case (byte_reg)
                    acsi_pkg::CHR_CLEAR: cmd_next = acsi_pkg::CMD_CLEAR;
                    acsi_pkg::CHR_EOL:   cmd_next = acsi_pkg::CMD_EOL;
                    acsi_pkg::CHR_SAVE: begin
                        saved_row_next = row_reg;
                        saved_col_next = col_reg;
                    end
                    acsi_pkg::CHR_RESTORE: begin
                        cmd_next = acsi_pkg::CMD_MOVE;
                        nr_next  = saved_row_reg;
                        nc_next  = saved_col_reg;
                    end
                    acsi_pkg::CHR_UP: begin
                        cmd_next     = acsi_pkg::CMD_MOVE;
                        nc_next      = col_reg;
                        pos_next     = row8 - step;
                        mod_col_next = 1'b0;
                    end
                    acsi_pkg::CHR_DOWN: begin
                        cmd_next     = acsi_pkg::CMD_MOVE;
                        nc_next      = col_reg;
                        pos_next     = row8 + step;
                        mod_col_next = 1'b0;
                    end
                    acsi_pkg::CHR_LEFT: begin
                        cmd_next     = acsi_pkg::CMD_MOVE;
                        nr_next      = row_reg;
                        pos_next     = col8 - step;
                        mod_col_next = 1'b1;
                    end
                    acsi_pkg::CHR_RIGHT: begin
                        cmd_next     = acsi_pkg::CMD_MOVE;
                        nr_next      = row_reg;
                        pos_next     = col8 + step;
                        mod_col_next = 1'b1;
                    end
                    acsi_pkg::CHR_POS_H, acsi_pkg::CHR_POS_F: begin
                        if (pcnt_reg == '0) begin
                            cmd_next = acsi_pkg::CMD_MOVE;
                        end else if (pos_ok) begin
                            cmd_next = acsi_pkg::CMD_MOVE;
                            nr_next  = pos_r_m1[acsi_pkg::ROW_W-1:0];
                            nc_next  = pos_c_m1[acsi_pkg::COL_W-1:0];
                        end
                    end
                    default: cmd_next = acsi_pkg::CMD_NONE;
                endcase
            end
        end

        // One attribute code per cycle
        if (cmd.sgr_step) begin
            sgr_idx_next = sgr_idx_inc;
            case (rd_val)
                acsi_pkg::SGR_BLINK:     attr_next = attr_reg | acsi_pkg::ATTR_BLINK_BIT;
                acsi_pkg::SGR_UNDERLINE: attr_next = attr_reg | acsi_pkg::ATTR_UNDERLINE_BIT;
                acsi_pkg::SGR_REVERSE:   attr_next = attr_reverse_reg;
                acsi_pkg::SGR_RESET:     attr_next = attr_default_reg;
                acsi_pkg::SGR_BOLD:      attr_next = attr_bold_reg;
                default:                 attr_next = attr_reg;
            endcase
        end

        if (cmd.mod_rem) begin
            if (mod_col_reg) nc_next = rem[acsi_pkg::COL_W-1:0];
            else             nr_next = rem[acsi_pkg::ROW_W-1:0];
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            byte_reg <= s_tdata[7:0];
            row_reg  <= s_tdata[12:8];
            col_reg  <= s_tdata[19:13];
        end
        show_reg    <= show_next;
        cmd_reg     <= cmd_next;
        nr_reg      <= nr_next;
        nc_reg      <= nc_next;
        pos_reg     <= pos_next;
        mod_col_reg <= mod_col_next;
        sgr_idx_reg <= sgr_idx_next;
        if (cmd.mod_quot) quot_reg <= quot_prod[23:16];
        if (cmd.load_out) begin
            m_tdata_reg <= {attr_reg, nc_reg, nr_reg, cmd_reg, show_reg,
                            (phase_reg != acsi_pkg::PH_IDLE)};
        end
    end

    // Parser state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= acsi_pkg::PH_IDLE;
            for (int i = 0; i < MAX_PARAMS; i++) pval_reg[i] <= 8'd0;
            pcnt_reg         <= '0;
            in_num_reg       <= 1'b0;
            lead_semi_reg    <= 1'b0;
            any_char_reg     <= 1'b0;
            saved_row_reg    <= '0;
            saved_col_reg    <= '0;
            attr_reg         <= acsi_pkg::ATTR_DEFAULT_RST;
            attr_default_reg <= acsi_pkg::ATTR_DEFAULT_RST;
            attr_reverse_reg <= acsi_pkg::ATTR_REVERSE_RST;
            attr_bold_reg    <= acsi_pkg::ATTR_BOLD_RST;
        end else begin
            phase_reg     <= phase_next;
            pval_reg      <= pval_next;
            pcnt_reg      <= pcnt_next;
            in_num_reg    <= in_num_next;
            lead_semi_reg <= lead_semi_next;
            any_char_reg  <= any_char_next;
            saved_row_reg <= saved_row_next;
            saved_col_reg <= saved_col_next;
            attr_reg      <= attr_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    acsi_pkg::CFG_ATTR_DEFAULT: attr_default_reg <= cfg_wdata;
                    acsi_pkg::CFG_ATTR_REVERSE: attr_reverse_reg <= cfg_wdata;
                    acsi_pkg::CFG_ATTR_BOLD:    attr_bold_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

// File: src/ansi_csi_terminal_parser_unit.sv
// Terminal escape-sequence parser.
// Input channel (s_): one received byte per word, with the display's cursor
// row and column before that byte. Result channel (m_): one word per input
// word, in order: sequence-open flag, show flag, command, target row and
// column, and the attribute in force after the byte.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write the default, reverse
// and bold attributes (index 0, 1, 2); write only while the unit is idle.
// Flow: one word at a time. A word is taken in the idle state, decoded in
// the decode state and registered in the output stage from the done state,
// which waits until the output register is free. A relative cursor move
// adds a reciprocal-multiply step and then a remainder step; an attribute
// command steps through its gathered parameters (up to MAX_PARAMS) one by
// one. A new byte is taken only after the previous one has run through the
// controller's capture/decode/load sequence.
// Reset (aresetn low at a clock edge): closes any sequence, clears the
// parameters and saved cursor, restores the attribute registers.
// Stall: a finished word waits in the output register; the unit still takes
// the next input word and holds it ready to load once m_tready frees it.
`timescale 1ns / 1ps

module ansi_csi_terminal_parser_unit #(
    parameter int MAX_PARAMS = 5
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [7:0] in_byte, [12:8] cur_row, [19:13] cur_col, [23:20] zero
    input  logic [acsi_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] in_sequence, [1] show_byte, [3:2] command, [8:4] new_row,
    // [15:9] new_col, [23:16] attribute
    output logic [acsi_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [acsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [acsi_pkg::CFG_W-1:0]         cfg_wdata
);

    acsi_pkg::ctrl_cmd_t  ctrl_cmd;
    acsi_pkg::dp_status_t dp_status;

    acsi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    acsi_dp #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (ctrl_cmd),
        .status    (dp_status)
    );

endmodule

// File: src/acsi_checker.sv
`timescale 1ns / 1ps
`include "ansi_csi_terminal_parser_unit_defines.svh"

module acsi_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [acsi_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic [1:0] out_cmd;
    assign out_cmd = m_tdata[3:2];

    // A stalled result word stays put
    `ACSI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // One word in flight: no back-to-back accept
    `ACSI_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input accepted while a word is in work")

    // Target is zero unless the command moves the cursor
    `ACSI_ASSERT_SAME(a_target_zero, aclk, aresetn, m_tvalid && (out_cmd != acsi_pkg::CMD_MOVE), m_tdata[15:4] == 12'd0, "target set without a move")

    // Displayed text carries no command and leaves no sequence open
    `ACSI_ASSERT_SAME(a_show_plain, aclk, aresetn, m_tvalid && m_tdata[1], !m_tdata[0] && (out_cmd == acsi_pkg::CMD_NONE), "shown byte with command or open sequence")

endmodule

bind ansi_csi_terminal_parser_unit acsi_checker u_acsi_checker (.*);

// File: test/term_parse_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the parser, keeps its own copy of the parser state
// and of the attribute registers, and compares every result word with the
// oldest prediction.
module term_parse_checker
    import acsi_pkg::*;
#(
    parameter int MAX_PARAMS = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   mismatches,
    output int                   pending,
    output int                   checked
);

    // Result word layout, lowest field last
    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        cmd_t              cmd;
        logic              show;
        logic              open;
    } term_result_t;

    phase_t            seq_phase;
    logic [7:0]        params [MAX_PARAMS];
    int                n_params;
    logic              in_digits;
    logic              lead_semi;
    logic              seen_param;
    logic [ROW_W-1:0]  saved_row;
    logic [COL_W-1:0]  saved_col;
    logic [ATTR_W-1:0] attr_now;
    logic [ATTR_W-1:0] attr_dflt;
    logic [ATTR_W-1:0] attr_rev;
    logic [ATTR_W-1:0] attr_bld;
    term_result_t      results_due [$];

    function automatic void clear_params();
        for (int k = 0; k < MAX_PARAMS; k++) params[k] = 8'd0;
        n_params   = 0;
        in_digits  = 1'b0;
        lead_semi  = 1'b0;
        seen_param = 1'b0;
    endfunction

    // Advance the parser by one byte and return the word it should produce
    function automatic term_result_t parse_term_byte(input logic [7:0] ch,
                                                     input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        term_result_t r;
        logic [7:0]   step;
        logic [7:0]   pos;
        logic [7:0]   hr;
        logic [7:0]   hc;
        logic         alpha;
        r     = '0;
        alpha = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
        if (ch == CHR_ESC) begin
            clear_params();
            seq_phase = PH_ESC;
        end else if (seq_phase == PH_IDLE) begin
            r.show = 1'b1;
        end else if (seq_phase == PH_ESC) begin
            seq_phase = (ch == CHR_LBRACKET) ? PH_CSI : PH_IDLE;
        end else if (!alpha) begin
            // gather digits; any other byte ends the current number
            if (!seen_param && ch == CHR_SEMI) lead_semi = 1'b1;
            seen_param = 1'b1;
            if (ch >= CHR_0 && ch <= CHR_9) begin
                if (in_digits) begin
                    params[n_params-1] = 8'(params[n_params-1] * 8'd10 + (ch - CHR_0));
                end else if (n_params < MAX_PARAMS) begin
                    params[n_params] = ch - CHR_0;
                    n_params++;
                    in_digits = 1'b1;
                end
            end else begin
                in_digits = 1'b0;
            end
        end else begin
            // final letter: close the sequence and run its command
            seq_phase = PH_IDLE;
            step = (n_params != 0) ? params[0] : 8'd1;
            case (ch)
                CHR_CLEAR: r.cmd = CMD_CLEAR;
                CHR_EOL:   r.cmd = CMD_EOL;
                CHR_SGR: begin
                    for (int k = 0; k < n_params; k++) begin
                        case (params[k])
                            SGR_BLINK:     attr_now = attr_now | ATTR_BLINK_BIT;
                            SGR_UNDERLINE: attr_now = attr_now | ATTR_UNDERLINE_BIT;
                            SGR_REVERSE:   attr_now = attr_rev;
                            SGR_RESET:     attr_now = attr_dflt;
                            SGR_BOLD:      attr_now = attr_bld;
                            default: ;
                        endcase
                    end
                end
                CHR_SAVE: begin
                    saved_row = row;
                    saved_col = col;
                end
                CHR_RESTORE: begin
                    r.cmd = CMD_MOVE;
                    r.row = saved_row;
                    r.col = saved_col;
                end
                CHR_UP, CHR_DOWN: begin
                    pos   = (ch == CHR_UP) ? 8'(row) - step : 8'(row) + step;
                    r.cmd = CMD_MOVE;
                    r.row = ROW_W'(pos % SCREEN_ROWS);
                    r.col = col;
                end
                CHR_LEFT, CHR_RIGHT: begin
                    pos   = (ch == CHR_LEFT) ? 8'(col) - step : 8'(col) + step;
                    r.cmd = CMD_MOVE;
                    r.row = row;
                    r.col = COL_W'(pos % SCREEN_COLS);
                end
                CHR_POS_H, CHR_POS_F: begin
                    if (n_params == 0) begin
                        r.cmd = CMD_MOVE;
                    end else if (n_params <= 2) begin
                        hr = params[0];
                        hc = 8'd1;
                        if (n_params == 2) begin
                            hc = params[1];
                        end else if (lead_semi) begin
                            hc = hr;
                            hr = 8'd1;
                        end
                        if (hr == 8'd0) hr = 8'd1;
                        if (hc == 8'd0) hc = 8'd1;
                        if (hr <= SCREEN_ROWS && hc < SCREEN_COLS) begin
                            r.cmd = CMD_MOVE;
                            r.row = ROW_W'(hr - 8'd1);
                            r.col = COL_W'(hc - 8'd1);
                        end
                    end
                end
                default: ;
            endcase
        end
        r.open = (seq_phase != PH_IDLE);
        r.attr = attr_now;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        term_result_t got;
        term_result_t want;
        if (!aresetn) begin
            clear_params();
            seq_phase = PH_IDLE;
            saved_row = '0;
            saved_col = '0;
            attr_now  = ATTR_DEFAULT_RST;
            attr_dflt = ATTR_DEFAULT_RST;
            attr_rev  = ATTR_REVERSE_RST;
            attr_bld  = ATTR_BOLD_RST;
            results_due.delete();
        end else begin
            // compare the word leaving the block with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = term_result_t'(m_tdata);
                if (results_due.size() == 0) begin
                    $error("result word %h arrived with nothing predicted", m_tdata);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("in_sequence", want.open, got.open);
                    check_field("show_byte", want.show, got.show);
                    check_field("command", want.cmd, got.cmd);
                    check_field("new_row", want.row, got.row);
                    check_field("new_col", want.col, got.col);
                    check_field("attribute", want.attr, got.attr);
                    checked++;
                end
            end
            // track register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ATTR_DEFAULT: attr_dflt = cfg_wdata;
                    CFG_ATTR_REVERSE: attr_rev  = cfg_wdata;
                    CFG_ATTR_BOLD:    attr_bld  = cfg_wdata;
                    default: ;
                endcase
            end
            // predict each accepted word
            if (s_tvalid && s_tready) begin
                results_due.push_back(parse_term_byte(s_tdata[BYTE_W-1:0],
                                                      s_tdata[BYTE_W +: ROW_W],
                                                      s_tdata[BYTE_W+ROW_W +: COL_W]));
            end
        end
        pending = results_due.size();
    end

endmodule

// File: test/tb_ansi_csi_terminal_parser_unit.sv
`timescale 1ns / 1ps

module tb_ansi_csi_terminal_parser_unit;
    import acsi_pkg::*;

    localparam int         MAX_PARAMS   = 5;
    localparam int         PHASE_BYTES  = 360;
    localparam logic [7:0] LC_A         = "a";

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SELDOM, RX_PATTERN} rx_mode_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int       mismatches;
    int       pending;
    int       checked;
    int       bytes_sent = 0;
    int       seqs_sent  = 0;
    int       settings   = 1;
    int       burst_left = 0;
    int       rx_cycle;
    int       hold_left;
    rx_mode_t rx_mode;

    ansi_csi_terminal_parser_unit #(.MAX_PARAMS(MAX_PARAMS)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    term_parse_checker #(.MAX_PARAMS(MAX_PARAMS)) u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver: change stall pattern now and then, with a long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_cycle  <= 0;
            hold_left <= 0;
            rx_mode   <= RX_ALWAYS;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 128 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
            if (rx_cycle % 2500 == 1200) begin
                hold_left <= 300;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    RX_SELDOM: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (rx_cycle % 7) < 3;
                endcase
            end
        end
    end

    function automatic logic [ROW_W-1:0] pick_row();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ROW_W'(SCREEN_ROWS);
            default: return ROW_W'($urandom_range(0, SCREEN_ROWS));
        endcase
    endfunction

    function automatic logic [COL_W-1:0] pick_col();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COL_W'(SCREEN_COLS - 1);
            default: return COL_W'($urandom_range(0, SCREEN_COLS - 1));
        endcase
    endfunction

    // Offer one word in bursts with random gaps; return once it is taken
    task automatic send_byte(input logic [7:0] ch, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - BYTE_W - ROW_W - COL_W){1'b0}}, col, row, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_any(input logic [7:0] ch);
        send_byte(ch, pick_row(), pick_col());
    endtask

    // ESC followed by the given text, all at one cursor position
    task automatic send_csi(input string body, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col);
        send_byte(CHR_ESC, row, col);
        for (int k = 0; k < body.len(); k++) send_byte(body[k], row, col);
    endtask

    task automatic send_number(input int v);
        logic [7:0] dig [$];
        if ($urandom_range(0, 7) == 0) send_any(CHR_0);
        do begin
            dig.push_front(CHR_0 + 8'(v % 10));
            v = v / 10;
        end while (v > 0);
        foreach (dig[k]) send_any(dig[k]);
    endtask

    function automatic logic [7:0] pick_final();
        logic [7:0] finals [11] = '{CHR_CLEAR, CHR_EOL, CHR_SGR, CHR_SAVE, CHR_RESTORE,
                                    CHR_UP, CHR_DOWN, CHR_RIGHT, CHR_LEFT,
                                    CHR_POS_H, CHR_POS_F};
        if ($urandom_range(0, 7) == 0) begin
            return ($urandom_range(0, 1) != 0) ? CHR_UP + 8'($urandom_range(0, 25))
                                               : LC_A + 8'($urandom_range(0, 25));
        end
        return finals[$urandom_range(0, 10)];
    endfunction

    function automatic int pick_value(input logic [7:0] fin);
        logic [7:0] codes [5] = '{SGR_RESET, SGR_BOLD, SGR_UNDERLINE, SGR_BLINK,
                                  SGR_REVERSE};
        if (fin == CHR_SGR && $urandom_range(0, 3) != 0) return codes[$urandom_range(0, 4)];
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 30);
            1:       return $urandom_range(0, 90);
            2:       return $urandom_range(0, 999);
            default: return $urandom_range(0, 9);
        endcase
    endfunction

    // Mostly ';', else any byte that is neither a letter, a digit nor ESC
    function automatic logic [7:0] pick_separator();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0) return CHR_SEMI;
        do c = 8'($urandom_range(0, 255));
        while ((c >= CHR_UP && c <= 8'h5A) || (c >= LC_A && c <= 8'h7A) ||
               (c >= CHR_0 && c <= CHR_9) || c == CHR_ESC);
        return c;
    endfunction

    // Well-formed control sequence with random parameters
    task automatic emit_csi();
        logic [7:0] fin;
        int         n_vals;
        fin = pick_final();
        send_any(CHR_ESC);
        send_any(CHR_LBRACKET);
        if ($urandom_range(0, 5) == 0) send_any(CHR_SEMI);
        n_vals = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 7) : $urandom_range(0, 2);
        for (int k = 0; k < n_vals; k++) begin
            if (k > 0) send_any(pick_separator());
            if ($urandom_range(0, 9) != 0) send_number(pick_value(fin));
        end
        send_any(fin);
        seqs_sent++;
    endtask

    // Plain text, stray escapes and sequences cut short
    task automatic emit_noise();
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 6)) send_any(8'($urandom_range(0, 255)));
            1: begin
                send_any(CHR_ESC);
                send_any(8'($urandom_range(0, 255)));
            end
            2: begin
                send_any(CHR_ESC);
                send_any(CHR_LBRACKET);
                send_number($urandom_range(0, 300));
                emit_csi();
            end
            default: begin
                send_any(CHR_ESC);
                send_any(CHR_LBRACKET);
                repeat ($urandom_range(1, 5)) send_any(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic run_random(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 9) < 7) emit_csi();
            else emit_noise();
        end
    endtask

    // Stop offering words and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);
    endtask

    task automatic write_attr_regs(input logic [7:0] dflt, input logic [7:0] rev,
                                   input logic [7:0] bold);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ATTR_DEFAULT;
        cfg_wdata <= dflt;
        @(posedge aclk);
        cfg_index <= CFG_ATTR_REVERSE;
        cfg_wdata <= rev;
        @(posedge aclk);
        cfg_index <= CFG_ATTR_BOLD;
        cfg_wdata <= bold;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // text at both byte extremes, then one sequence per special case
        send_byte(8'h00, 0, 0);
        send_byte(8'hFF, 24, 79);
        send_csi("x", 3, 3);
        send_csi("[J", 5, 40);
        send_csi("[7m", 6, 6);
        send_csi("[;9H", 10, 10);
        send_csi("[D", 12, 0);
        send_csi("[s", 24, 79);
        send_csi("[u", 0, 0);

        // random traffic under several attribute settings
        run_random(PHASE_BYTES);
        drain();
        write_attr_regs(8'h00, 8'h00, 8'h00);
        run_random(PHASE_BYTES);
        drain();
        write_attr_regs(8'hFF, 8'hFF, 8'hFF);
        run_random(PHASE_BYTES);
        drain();
        write_attr_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
        run_random(PHASE_BYTES);
        drain();
        write_attr_regs(8'h00, 8'hFF, 8'($urandom_range(0, 255)));
        run_random(PHASE_BYTES);

        drain();
        repeat (16) @(posedge aclk);
        $display("tb: %0d bytes sent, %0d control sequences, %0d result words checked",
                 bytes_sent, seqs_sent, checked);
        $display("tb: %0d attribute register settings, all-zero and all-ones included",
                 settings);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_ansi_csi_terminal_parser_unit: done, clean");
        end else begin
            $display("tb_ansi_csi_terminal_parser_unit: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("tb_ansi_csi_terminal_parser_unit: done, errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/acsi_pkg.sv
src/acsi_ctrl.sv
src/acsi_dp.sv
src/ansi_csi_terminal_parser_unit.sv
src/acsi_checker.sv
test/term_parse_checker.sv
test/tb_ansi_csi_terminal_parser_unit.sv
